@@ rtl/smt_pkg.sv @@
package smt_pkg;

    localparam int BYTE_W      = 8;
    localparam int TYPE_W      = 3;
    localparam int TICK_W      = 31;
    localparam int ID_W        = 16;
    // rate (8 signed) times tick (31 unsigned) needs 39 signed bits
    localparam int PROD_W      = BYTE_W + TICK_W;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int ROM_DEPTH   = 256;

    // triangle wave constants
    localparam int TRI_PEAK    = 127;
    localparam int TRI_RAMP    = 252;
    localparam int QUARTER     = 64;

    // per-type sine index constants
    localparam logic [BYTE_W-1:0] RIGID_X_MUL    = 8'd17;
    localparam logic [BYTE_W-1:0] RIGID_Y_MUL    = 8'd23;
    localparam logic [BYTE_W-1:0] COS_SHIFT      = 8'd64;
    localparam logic [BYTE_W-1:0] PART_TICK_MUL  = 8'd31;
    localparam logic [BYTE_W-1:0] PART_ID_MUL    = 8'd97;

    typedef enum logic [TYPE_W-1:0] {
        MOT_STATIC   = 3'd0,
        MOT_FLOW     = 3'd1,
        MOT_RIGID    = 3'd2,
        MOT_ORGANIC  = 3'd3,
        MOT_PARTICLE = 3'd4
    } motion_t;

    // one classified item waiting for the back end
    typedef struct packed {
        motion_t                   kind;
        logic [BYTE_W-1:0]         amp;
        logic [BYTE_W-1:0]         anchor_x;
        logic [BYTE_W-1:0]         anchor_y;
        logic [BYTE_W-1:0]         idx_x;
        logic [BYTE_W-1:0]         idx_y;
        logic signed [PROD_W-1:0]  drift_prod;
    } smt_entry_t;

    // queue status toward the front and back ends
    typedef struct packed {
        logic full;
        logic valid;
    } smt_qstat_t;

    typedef logic [ROM_DEPTH-1:0][BYTE_W-1:0] tri_rom_t;

    // triangle sine, values -127..127
    function automatic tri_rom_t build_tri_rom();
        tri_rom_t r;
        int q;
        int p;
        int mag;
        int v;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            q   = i / QUARTER;
            p   = (i % QUARTER) * 4;
            mag = (q == 0 || q == 2) ? p : (TRI_RAMP - p);
            v   = (mag * TRI_PEAK) / TRI_RAMP;
            r[i] = BYTE_W'((q >= 2) ? -v : v);
        end
        return r;
    endfunction

    localparam tri_rom_t TRI_ROM = build_tri_rom();

endpackage

@@ rtl/smt_front.sv @@
module smt_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rate, freq, amp, phase, anchor_x, anchor_y, tick_count, object_id
    input  logic [smt_pkg::IN_TDATA_W-1:0] s_tdata,
    // motion_type
    input  logic [smt_pkg::TYPE_W-1:0]     s_tuser,
    input  smt_pkg::smt_qstat_t            qstat,
    output logic                          push,
    output smt_pkg::smt_entry_t            push_entry
);
    import smt_pkg::*;

    logic signed [BYTE_W-1:0] rate;
    logic [BYTE_W-1:0]        freq;
    logic [BYTE_W-1:0]        phase;
    logic [TICK_W-1:0]        tick;
    logic [ID_W-1:0]          obj_id;
    logic [BYTE_W-1:0]        tick8;
    logic [BYTE_W-1:0]        tf8;
    logic [BYTE_W-1:0]        org8;
    logic [BYTE_W-1:0]        part8;

    // unpack fields
    assign rate   = $signed(s_tdata[7:0]);
    assign freq   = s_tdata[15:8];
    assign phase  = s_tdata[31:24];
    assign tick   = s_tdata[78:48];
    assign obj_id = s_tdata[94:79];

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && s_tready;

    // only the low byte of each phase product matters
    assign tick8 = tick[BYTE_W-1:0];
    assign tf8   = BYTE_W'(tick8 * freq);
    assign org8  = tf8 + phase;
    assign part8 = BYTE_W'(tick8 * PART_TICK_MUL) + BYTE_W'(obj_id[BYTE_W-1:0] * PART_ID_MUL);

    // classify type, pick sine indices, exact drift / fall product
    always_comb begin
        push_entry.kind       = MOT_STATIC;
        push_entry.amp        = s_tdata[23:16];
        push_entry.anchor_x   = s_tdata[39:32];
        push_entry.anchor_y   = s_tdata[47:40];
        push_entry.idx_x      = '0;
        push_entry.idx_y      = '0;
        push_entry.drift_prod = PROD_W'(rate) * PROD_W'($signed({1'b0, tick}));
        unique case (s_tuser)
            MOT_FLOW: begin
                push_entry.kind  = MOT_FLOW;
                push_entry.idx_y = tf8;
            end
            MOT_RIGID: begin
                push_entry.kind  = MOT_RIGID;
                push_entry.idx_x = BYTE_W'(tick8 * RIGID_X_MUL);
                push_entry.idx_y = BYTE_W'(tick8 * RIGID_Y_MUL) + COS_SHIFT;
            end
            MOT_ORGANIC: begin
                push_entry.kind  = MOT_ORGANIC;
                push_entry.idx_x = org8;
                push_entry.idx_y = org8 + COS_SHIFT;
            end
            MOT_PARTICLE: begin
                push_entry.kind  = MOT_PARTICLE;
                push_entry.idx_x = part8;
            end
            default: begin
                push_entry.kind  = MOT_STATIC;
            end
        endcase
    end

endmodule

@@ rtl/smt_queue.sv @@
module smt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  smt_pkg::smt_entry_t push_entry,
    input  logic                pop,
    output smt_pkg::smt_entry_t pop_entry,
    output smt_pkg::smt_qstat_t qstat
);
    import smt_pkg::*;

    smt_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg,  count_next;
    logic                  do_push;
    logic                  do_pop;

    assign qstat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign qstat.valid = (count_reg != '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && qstat.valid;
    assign pop_entry   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/smt_back.sv @@
module smt_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  smt_pkg::smt_qstat_t             qstat,
    input  smt_pkg::smt_entry_t             pop_entry,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pos_x, pos_y
    output logic [smt_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import smt_pkg::*;

    localparam int OFF_W  = 10;   // (sine * amp) >>> 7
    localparam int SUM_W  = 11;
    localparam int FALL_W = PROD_W - 4;
    localparam int FSUM_W = FALL_W + 1;

    logic                     out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]        pos_x_reg, pos_x_next;
    logic [BYTE_W-1:0]        pos_y_reg, pos_y_next;

    logic signed [BYTE_W-1:0] sin_x, sin_y;
    logic signed [16:0]       scl_x, scl_y;
    logic signed [OFF_W-1:0]  off_x, off_y;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic [BYTE_W-1:0]        drift8;
    logic signed [FALL_W-1:0] fall;
    logic signed [FSUM_W-1:0] fall_sum;
    logic [BYTE_W-1:0]        clamp_x, clamp_y, clamp_fall;

    assign pop = qstat.valid && (!out_valid_reg || m_tready);

    // sine lookup and amplitude scaling
    assign sin_x = $signed(TRI_ROM[pop_entry.idx_x]);
    assign sin_y = $signed(TRI_ROM[pop_entry.idx_y]);
    assign scl_x = sin_x * $signed({1'b0, pop_entry.amp});
    assign scl_y = sin_y * $signed({1'b0, pop_entry.amp});
    assign off_x = scl_x[16:7];
    assign off_y = scl_y[16:7];
    assign sum_x = $signed({3'b000, pop_entry.anchor_x}) + SUM_W'(off_x);
    assign sum_y = $signed({3'b000, pop_entry.anchor_y}) + SUM_W'(off_y);

    // truncating divide by 32, only the low byte survives the wrap
    assign drift8 = pop_entry.drift_prod[12:5]
                  + BYTE_W'(pop_entry.drift_prod[PROD_W-1] && (pop_entry.drift_prod[4:0] != '0));

    // truncating divide by 16 for gravity
    assign fall = pop_entry.drift_prod[PROD_W-1:4]
                + FALL_W'(pop_entry.drift_prod[PROD_W-1] && (pop_entry.drift_prod[3:0] != '0));
    assign fall_sum = $signed({{(FSUM_W-BYTE_W){1'b0}}, pop_entry.anchor_y}) + FSUM_W'(fall);

    // saturate to 0..255
    always_comb begin
        clamp_x = sum_x[BYTE_W-1:0];
        if (sum_x < 0) begin
            clamp_x = '0;
        end else if (sum_x > SUM_W'(255)) begin
            clamp_x = '1;
        end
        clamp_y = sum_y[BYTE_W-1:0];
        if (sum_y < 0) begin
            clamp_y = '0;
        end else if (sum_y > SUM_W'(255)) begin
            clamp_y = '1;
        end
        clamp_fall = fall_sum[BYTE_W-1:0];
        if (fall_sum < 0) begin
            clamp_fall = '0;
        end else if (fall_sum > FSUM_W'(255)) begin
            clamp_fall = '1;
        end
    end

    // select result by motion type, load output register
    always_comb begin
        out_valid_next = out_valid_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop) begin
            out_valid_next = 1'b1;
            unique case (pop_entry.kind)
                MOT_FLOW: begin
                    pos_x_next = pop_entry.anchor_x + drift8;
                    pos_y_next = clamp_y;
                end
                MOT_RIGID, MOT_ORGANIC: begin
                    pos_x_next = clamp_x;
                    pos_y_next = clamp_y;
                end
                MOT_PARTICLE: begin
                    pos_x_next = clamp_x;
                    pos_y_next = clamp_fall;
                end
                default: begin
                    pos_x_next = pop_entry.anchor_x;
                    pos_y_next = pop_entry.anchor_y;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pos_y_reg, pos_x_reg};

endmodule

@@ rtl/sprite_motion_tick.sv @@
// An accepted item is written into the queue, then popped and loaded into the registered output.
// One item per cycle unless stalled; the front end computes sine indices and the tick product,
// the back end does the sine lookup, scaling and clamping into a registered output.
// A four-entry queue between them absorbs output stalls; s_tready drops only when it is full.
// Reset: synchronous active-low aresetn empties the queue and clears m_tvalid.
module sprite_motion_tick (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rate, freq, amp, phase, anchor_x, anchor_y, tick_count, object_id, zero pad
    input  logic [smt_pkg::IN_TDATA_W-1:0]  s_tdata,
    // motion_type
    input  logic [smt_pkg::TYPE_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pos_x, pos_y
    output logic [smt_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import smt_pkg::*;

    smt_qstat_t qstat;
    smt_entry_t push_entry;
    smt_entry_t pop_entry;
    logic       push;
    logic       pop;

    smt_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    smt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    smt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ rtl/smt_checker.sv @@
module smt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [smt_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import smt_pkg::*;

    localparam int HELD_MAX = QUEUE_DEPTH + 1;
    localparam int HELD_W   = $clog2(HELD_MAX + 1);

    logic              s_fire;
    logic              m_fire;
    logic [HELD_W-1:0] held_reg, held_next;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // items accepted but not yet delivered
    always_comb begin
        held_next = held_reg;
        if (s_fire && !m_fire) begin
            held_next = held_reg + 1'b1;
        end else if (m_fire && !s_fire) begin
            held_next = held_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result without an item behind it
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> held_reg != '0)
        else $error("result without a pending item");

    // storage never holds more than queue plus output register
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= HELD_W'(HELD_MAX))
        else $error("more items held than storage allows");

    // an empty block always takes input
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg == '0 |-> s_tready)
        else $error("idle block not ready");

    // reset clears the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

endmodule

bind sprite_motion_tick smt_checker u_smt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_sprite_motion_tick.sv @@
module tb_sprite_motion_tick;
    import smt_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RANDOM_CNT  = 2000;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 10;

    // one object update waiting to be sent
    typedef struct {
        logic [TYPE_W-1:0]     kind;
        logic [IN_TDATA_W-1:0] data;
        bit                    drain;   // hold off until all positions are back
    } obj_item_t;

    typedef struct {
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
    } pos_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // rate, freq, amp, phase, anchor_x, anchor_y, tick_count, object_id, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    // motion_type
    logic [TYPE_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // pos_x, pos_y
    logic [OUT_TDATA_W-1:0] m_tdata;

    obj_item_t pending_q[$];
    pos_t      pos_q[$];
    int        err_cnt     = 0;
    int        idle_cycles = 0;
    bit        s_taken     = 1'b0;
    int        send_gap    = 0;
    int        send_burst  = 0;
    int        recv_stall  = 0;
    int        recv_burst  = 0;

    sprite_motion_tick uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // triangle wave over one byte of phase, -127..127
    function automatic int tri_wave(logic [7:0] idx);
        int quad;
        int ramp;
        int mag;
        int v;
        quad = int'(idx[7:6]);
        ramp = int'(idx[5:0]) * 4;
        mag  = (quad == 0 || quad == 2) ? ramp : (252 - ramp);
        v    = (mag * 127) / 252;
        return (quad >= 2) ? -v : v;
    endfunction

    // wave value scaled by amplitude, floor division by 128
    function automatic int wave_offset(int s, logic [7:0] amp);
        int a;
        int prod;
        a    = int'(amp);
        prod = s * a;
        return prod >>> 7;
    endfunction

    function automatic logic [7:0] sat8(longint v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    // expected displaced position of one object
    function automatic pos_t calc_position(logic [TYPE_W-1:0] kind,
                                           logic [IN_TDATA_W-1:0] d);
        logic signed [7:0] rate;
        logic [7:0]        freq;
        logic [7:0]        amp;
        logic [7:0]        phase;
        longint            ax;
        longint            ay;
        longint            rl;
        longint            tl;
        longint            shift;
        bit [30:0]         tk;
        bit [15:0]         oid;
        logic [7:0]        ia;
        logic [7:0]        ib;
        pos_t              p;
        rate  = d[7:0];
        freq  = d[15:8];
        amp   = d[23:16];
        phase = d[31:24];
        ax    = longint'(d[39:32]);
        ay    = longint'(d[47:40]);
        tk    = d[78:48];
        oid   = d[94:79];
        rl    = longint'(rate);
        tl    = longint'(tk);
        p.x   = ax[7:0];
        p.y   = ay[7:0];
        case (motion_t'(kind))
            MOT_FLOW: begin
                shift = (ax + (rl * tl) / 32) % 256;
                if (shift < 0) shift += 256;
                p.x = shift[7:0];
                ia  = 8'(tk * freq);
                p.y = sat8(ay + wave_offset(tri_wave(ia), amp));
            end
            MOT_RIGID: begin
                ia  = 8'(tk * 17);
                ib  = 8'(tk * 23 + 64);
                p.x = sat8(ax + wave_offset(tri_wave(ia), amp));
                p.y = sat8(ay + wave_offset(tri_wave(ib), amp));
            end
            MOT_ORGANIC: begin
                ia  = 8'(tk * freq + phase);
                ib  = ia + 8'd64;
                p.x = sat8(ax + wave_offset(tri_wave(ia), amp));
                p.y = sat8(ay + wave_offset(tri_wave(ib), amp));
            end
            MOT_PARTICLE: begin
                ia  = 8'(tk * 31 + oid * 97);
                p.x = sat8(ax + wave_offset(tri_wave(ia), amp));
                p.y = sat8(ay + (rl * tl) / 16);
            end
            default: ;  // static and unknown codes keep the anchor
        endcase
        return p;
    endfunction

    task automatic add_obj(logic [2:0] kind, logic [7:0] rate, logic [7:0] freq,
                           logic [7:0] amp, logic [7:0] phase, logic [7:0] ax,
                           logic [7:0] ay, logic [30:0] tick, logic [15:0] oid,
                           bit drain);
        obj_item_t it;
        it.kind  = kind;
        it.data  = {1'b0, oid, tick, ay, ax, phase, amp, freq, rate};
        it.drain = drain;
        pending_q.push_back(it);
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'd0;
        if (r < 16) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [30:0] rand_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 31'($urandom_range(0, 1023));
        if (r < 80) return 31'($urandom);
        if (r < 90) return 31'h7FFF_FFFF - 31'($urandom_range(0, 255));
        return 31'($urandom_range(0, 3));
    endfunction

    function automatic logic [2:0] rand_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return 3'($urandom_range(5, 7));
        if (r < 14) return MOT_STATIC;
        return 3'($urandom_range(MOT_FLOW, MOT_PARTICLE));
    endfunction

    // sender: next item or a gap once the current one is taken
    always @(negedge aclk) begin
        if (aresetn && (s_taken || !s_tvalid)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain && pos_q.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tuser  <= pending_q[0].kind;
                s_tdata  <= pending_q[0].data;
                s_tvalid <= 1'b1;
                void'(pending_q.pop_front());
                if (send_burst > 0) begin
                    send_burst--;
                end else if ($urandom_range(0, 99) < 2) begin
                    send_burst = $urandom_range(50, 150);
                end else begin
                    send_gap = pick_gap();
                end
            end
        end
    end

    // receiver: random back-pressure with stall-free stretches
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_burst > 0) begin
                    recv_burst--;
                end else if ($urandom_range(0, 99) < 2) begin
                    recv_burst = $urandom_range(50, 150);
                end else if ($urandom_range(0, 99) < 30) begin
                    recv_stall = pick_gap();
                end
            end
        end
    end

    // accepted items feed the expected positions, results are checked in order
    always @(posedge aclk) begin
        pos_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pos_q.push_back(calc_position(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (pos_q.size() == 0) begin
                    $display("%0t: unexpected position x=%0d y=%0d", $time,
                             m_tdata[7:0], m_tdata[15:8]);
                    err_cnt++;
                end else begin
                    want = pos_q.pop_front();
                    if (m_tdata[7:0] !== want.x) begin
                        $display("%0t: pos_x expected %0d actual %0d", $time,
                                 want.x, m_tdata[7:0]);
                        err_cnt++;
                    end
                    if (m_tdata[15:8] !== want.y) begin
                        $display("%0t: pos_y expected %0d actual %0d", $time,
                                 want.y, m_tdata[15:8]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        // static extremes and unknown codes
        add_obj(MOT_STATIC, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 31'h7FFF_FFFF,
                16'hFFFF, 0);
        add_obj(MOT_STATIC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 31'd0, 16'd0, 0);
        add_obj(3'd5, 8'h80, 8'hAA, 8'hFF, 8'h55, 8'd12, 8'd200, 31'd12345, 16'hA5A5, 0);
        add_obj(3'd6, 8'h7F, 8'h55, 8'hFF, 8'hAA, 8'd240, 8'd3, 31'h5555_5555, 16'h5A5A, 0);
        add_obj(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd255, 31'h7FFF_FFFF, 16'hFFFF, 0);
        // flow: wrap both ways, truncation toward zero, wave clamping
        add_obj(MOT_FLOW, 8'h7F, 8'd3, 8'd40, 8'd0, 8'd255, 8'd128, 31'h7FFF_FFFF, 16'd0, 0);
        add_obj(MOT_FLOW, 8'h80, 8'd7, 8'd40, 8'd0, 8'd0, 8'd128, 31'h7FFF_FFFF, 16'd0, 0);
        add_obj(MOT_FLOW, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd10, 8'd10, 31'd31, 16'd0, 0);
        add_obj(MOT_FLOW, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10, 31'd33, 16'd0, 0);
        add_obj(MOT_FLOW, 8'd1, 8'd1, 8'hFF, 8'd0, 8'd100, 8'd255, 31'd64, 16'd0, 0);
        add_obj(MOT_FLOW, 8'd1, 8'd1, 8'hFF, 8'd0, 8'd100, 8'd0, 31'd192, 16'd0, 0);
        // rigid at tick zero and with clamping at both ends
        add_obj(MOT_RIGID, 8'd0, 8'd0, 8'hFF, 8'd0, 8'd0, 8'd0, 31'd0, 16'd0, 0);
        add_obj(MOT_RIGID, 8'd0, 8'd0, 8'hFF, 8'd0, 8'd255, 8'd255, 31'd4, 16'd0, 0);
        add_obj(MOT_RIGID, 8'd0, 8'd0, 8'hFF, 8'd0, 8'd0, 8'd0, 31'h7FFF_FFFF, 16'd0, 0);
        // organic with phase wrap
        add_obj(MOT_ORGANIC, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd255, 8'd0, 31'h7FFF_FFFF,
                16'd0, 0);
        add_obj(MOT_ORGANIC, 8'd0, 8'd0, 8'hFF, 8'd64, 8'd0, 8'd255, 31'd0, 16'd0, 0);
        add_obj(MOT_ORGANIC, 8'd0, 8'd1, 8'hFF, 8'd192, 8'd128, 8'd128, 31'd0, 16'd0, 0);
        // particle: huge fall both ways, id at extremes
        add_obj(MOT_PARTICLE, 8'h7F, 8'd0, 8'hFF, 8'd0, 8'd255, 8'd0, 31'h7FFF_FFFF,
                16'hFFFF, 0);
        add_obj(MOT_PARTICLE, 8'h80, 8'd0, 8'hFF, 8'd0, 8'd0, 8'd255, 31'h7FFF_FFFF,
                16'd0, 0);
        add_obj(MOT_PARTICLE, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd50, 8'd50, 31'd15, 16'd1, 0);
        add_obj(MOT_PARTICLE, 8'hFF, 8'd0, 8'd128, 8'd0, 8'd50, 8'd50, 31'd17, 16'd2, 0);

        // random objects, with drain points along the way
        for (int i = 0; i < RANDOM_CNT; i++) begin
            add_obj(rand_kind(), 8'($urandom_range(0, 255)), rand_byte(), rand_byte(),
                    rand_byte(), rand_byte(), rand_byte(), rand_tick(),
                    16'($urandom_range(0, 65535)), i == 0 || i == 700 || i == 1400);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // drain everything
        while (pending_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (pos_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
